/* src/aarm_pkg.sv */
// ----------------------------------------------------------------------------
// aarm_pkg
// shared types, constants and the q4.30 multiply for the axis-angle rotation
// matrix pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package aarm_pkg;

	localparam int AX_W      = 16;
	localparam int ANG_W     = 24;
	localparam int OUT_W     = 16;
	localparam int VAL_W     = 34;
	localparam int L2_W      = 32;
	localparam int LEN_W     = 32;
	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 31;
	localparam int REM_W     = 14;

	// register stages ahead of the square root and ahead of the cordic
	localparam int FRONT_AX  = 2;
	localparam int FRONT_ANG = 4;

	localparam int          CORDIC_STEPS_DEF  = 16;
	localparam int          OUT_FRAC_BITS_DEF = 14;
	localparam int          UNITS_QUARTER     = 11520;
	localparam logic [17:0] RAD_PER_UNIT      = 18'd146409;
	// 45 * 183, moves the turn count above zero without changing it mod 45
	localparam int          TURN_OFFSET       = 8235;
	localparam int          RECIP_45          = 1456;
	localparam int          TURN_DIV          = 45;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [AX_W-1:0]         mag_t;
	typedef logic [DIV_STEPS-1:0]    quot_t;

	localparam val_t ONE_Q30         = val_t'(1 << 30);
	localparam val_t CORDIC_GAIN_INV = val_t'(32'h26DD3B6A);

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_90,
		QUAD_180,
		QUAD_270
	} quad_t;

	typedef struct packed {
		logic       zero;
		logic [2:0] neg;
	} flags_t;

	typedef struct packed {
		flags_t flags;
		mag_t   mag_x;
		mag_t   mag_y;
		mag_t   mag_z;
	} axis_tag_t;

	localparam logic [31:0] ATAN_Q30 [0:31] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	localparam logic signed [2*VAL_W-1:0] MUL_HALF = (2*VAL_W)'(1) << 29;

	// q4.30 product, rounded half up
	function automatic val_t mul_q30(val_t a, val_t b);
		logic signed [2*VAL_W-1:0] p;
		p = (2*VAL_W)'(a) * (2*VAL_W)'(b) + MUL_HALF;
		return val_t'(p >>> 30);
	endfunction

endpackage

`default_nettype wire

/* src/aarm_cordic.sv */
// ----------------------------------------------------------------------------
// aarm_cordic
// unrolled rotation-mode cordic, one iteration per stage, then quadrant fold
// ----------------------------------------------------------------------------
`default_nettype none

module aarm_cordic import aarm_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire  logic  clk,
	input  wire  logic  en,
	input  wire  val_t  z0,
	input  wire  quad_t quad,
	output val_t        cos_v,
	output val_t        sin_v
);

	val_t  x_s [0:CORDIC_STEPS];
	val_t  y_s [0:CORDIC_STEPS];
	val_t  z_s [0:CORDIC_STEPS];
	quad_t q_s [0:CORDIC_STEPS];
	val_t  cos_q, sin_q;

	assign x_s[0] = CORDIC_GAIN_INV;
	assign y_s[0] = '0;
	assign z_s[0] = z0;
	assign q_s[0] = quad;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
		val_t dx, dy, ang;
		assign dx  = x_s[k] >>> k;
		assign dy  = y_s[k] >>> k;
		assign ang = val_t'(ATAN_Q30[k]);

		always_ff @(posedge clk) begin
			if (en) begin
				// z >= 0 rotates forward
				if (!z_s[k][VAL_W-1]) begin
					x_s[k+1] <= x_s[k] - dy;
					y_s[k+1] <= y_s[k] + dx;
					z_s[k+1] <= z_s[k] - ang;
				end else begin
					x_s[k+1] <= x_s[k] + dy;
					y_s[k+1] <= y_s[k] - dx;
					z_s[k+1] <= z_s[k] + ang;
				end
				q_s[k+1] <= q_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[CORDIC_STEPS])
				QUAD_0: begin
					cos_q <= x_s[CORDIC_STEPS];
					sin_q <= y_s[CORDIC_STEPS];
				end
				QUAD_90: begin
					cos_q <= -y_s[CORDIC_STEPS];
					sin_q <= x_s[CORDIC_STEPS];
				end
				QUAD_180: begin
					cos_q <= -x_s[CORDIC_STEPS];
					sin_q <= -y_s[CORDIC_STEPS];
				end
				default: begin
					cos_q <= y_s[CORDIC_STEPS];
					sin_q <= -x_s[CORDIC_STEPS];
				end
			endcase
		end
	end

	assign cos_v = cos_q;
	assign sin_v = sin_q;

endmodule

`default_nettype wire

/* src/aarm_isqrt.sv */
// ----------------------------------------------------------------------------
// aarm_isqrt
// pipelined digit-by-digit square root of the squared length shifted by 32,
// one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module aarm_isqrt import aarm_pkg::*; (
	input  wire  logic             clk,
	input  wire  logic             arst_n,
	input  wire  logic             en,
	input  wire  logic             in_vld,
	input  wire  logic [L2_W-1:0]  l2,
	input  wire  axis_tag_t        in_tag,
	output logic                   out_vld,
	output logic [LEN_W-1:0]       len,
	output axis_tag_t              out_tag
);

	logic             vld_s  [0:SQ_STEPS];
	logic [L2_W-1:0]  l2_s   [0:SQ_STEPS];
	logic [35:0]      rem_s  [0:SQ_STEPS];
	logic [LEN_W-1:0] root_s [0:SQ_STEPS];
	axis_tag_t        tag_s  [0:SQ_STEPS];

	assign vld_s[0]  = in_vld;
	assign l2_s[0]   = l2;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign tag_s[0]  = in_tag;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
		logic [1:0]  pair;
		logic [35:0] remn, trial;

		// the low half of the radicand is all zeros
		if (k < L2_W/2) begin : g_in
			assign pair = l2_s[k][L2_W-1-2*k -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign remn  = {rem_s[k][33:0], pair};
		assign trial = {2'b00, root_s[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				l2_s[k+1]  <= l2_s[k];
				tag_s[k+1] <= tag_s[k];
				if (remn >= trial) begin
					rem_s[k+1]  <= remn - trial;
					root_s[k+1] <= {root_s[k][LEN_W-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= remn;
					root_s[k+1] <= {root_s[k][LEN_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_s[SQ_STEPS];
	assign len     = root_s[SQ_STEPS];
	assign out_tag = tag_s[SQ_STEPS];

endmodule

`default_nettype wire

/* src/aarm_div.sv */
// ----------------------------------------------------------------------------
// aarm_div
// three-lane restoring divider, component magnitude * 2^46 over the length,
// one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module aarm_div import aarm_pkg::*; (
	input  wire  logic             clk,
	input  wire  logic             arst_n,
	input  wire  logic             en,
	input  wire  logic             in_vld,
	input  wire  logic [LEN_W-1:0] len,
	input  wire  axis_tag_t        in_tag,
	output logic                   out_vld,
	output flags_t                 out_flags,
	output quot_t                  quot_x,
	output quot_t                  quot_y,
	output quot_t                  quot_z
);

	logic             vld_s [0:DIV_STEPS];
	logic [LEN_W-1:0] len_s [0:DIV_STEPS];
	flags_t           flg_s [0:DIV_STEPS];
	logic [LEN_W-1:0] rem_s [0:DIV_STEPS][3];
	quot_t            quo_s [0:DIV_STEPS][3];

	assign vld_s[0]    = in_vld;
	assign len_s[0]    = len;
	assign flg_s[0]    = in_tag.flags;
	// the dividend's low 31 bits are zero, so only its head is loaded
	assign rem_s[0][0] = {1'b0, in_tag.mag_x, 15'd0};
	assign rem_s[0][1] = {1'b0, in_tag.mag_y, 15'd0};
	assign rem_s[0][2] = {1'b0, in_tag.mag_z, 15'd0};
	assign quo_s[0][0] = '0;
	assign quo_s[0][1] = '0;
	assign quo_s[0][2] = '0;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		for (genvar j = 0; j < 3; j++) begin : g_lane
			logic [LEN_W:0] rs;
			assign rs = {rem_s[k][j], 1'b0};

			always_ff @(posedge clk) begin
				if (en) begin
					if (rs >= {1'b0, len_s[k]}) begin
						rem_s[k+1][j] <= LEN_W'(rs - {1'b0, len_s[k]});
						quo_s[k+1][j] <= {quo_s[k][j][DIV_STEPS-2:0], 1'b1};
					end else begin
						rem_s[k+1][j] <= LEN_W'(rs);
						quo_s[k+1][j] <= {quo_s[k][j][DIV_STEPS-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[k+1] <= len_s[k];
				flg_s[k+1] <= flg_s[k];
			end
		end
	end

	assign out_vld   = vld_s[DIV_STEPS];
	assign out_flags = flg_s[DIV_STEPS];
	assign quot_x    = quo_s[DIV_STEPS][0];
	assign quot_y    = quo_s[DIV_STEPS][1];
	assign quot_z    = quo_s[DIV_STEPS][2];

endmodule

`default_nettype wire

/* src/aarm_dly.sv */
// ----------------------------------------------------------------------------
// aarm_dly
// enabled shift line that lines cosine and sine up with the unit axis
// ----------------------------------------------------------------------------
`default_nettype none

module aarm_dly #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  wire  logic             clk,
	input  wire  logic             en,
	input  wire  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0]       dout
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int k = 1; k < DEPTH; k++) begin
				tap_q[k] <= tap_q[k-1];
			end
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule

`default_nettype wire

/* src/aarm_mat.sv */
// ----------------------------------------------------------------------------
// aarm_mat
// signs the unit axis, forms the rodrigues products and sums, rounds and
// saturates the nine entries into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module aarm_mat import aarm_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  wire  logic  clk,
	input  wire  logic  arst_n,
	input  wire  logic  en,
	input  wire  logic  in_vld,
	input  wire  flags_t flags,
	input  wire  quot_t quot_x,
	input  wire  quot_t quot_y,
	input  wire  quot_t quot_z,
	input  wire  val_t  cos_v,
	input  wire  val_t  sin_v,
	output logic        out_vld,
	output logic signed [OUT_W-1:0] ent [9],
	output logic        zero
);

	localparam int SH = 30 - OUT_FRAC_BITS;
	localparam logic signed [VAL_W+1:0] RND = (SH > 0) ? ((VAL_W+2)'(1) << (SH - 1)) : '0;
	localparam logic signed [VAL_W+1:0] SAT_HI = (VAL_W+2)'(32767);
	localparam logic signed [VAL_W+1:0] SAT_LO = -(VAL_W+2)'(32768);

	function automatic logic signed [OUT_W-1:0] to_out(logic signed [VAL_W:0] v);
		logic signed [VAL_W+1:0] r;
		r = ((VAL_W+2)'(v) + RND) >>> SH;
		if (r > SAT_HI) begin
			return OUT_W'(SAT_HI);
		end else if (r < SAT_LO) begin
			return OUT_W'(SAT_LO);
		end
		return OUT_W'(r);
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic zero_s1, zero_s2, zero_s3, zero_s4;
	val_t u_s1 [3];
	val_t c_s1, s_s1, t_s1;
	val_t u_s2 [3];
	val_t tu_s2 [3];
	val_t su_s2 [3];
	val_t c_s2;
	val_t txx_s3, txy_s3, txz_s3, tyy_s3, tyz_s3, tzz_s3;
	val_t su_s3 [3];
	val_t c_s3;
	logic signed [OUT_W-1:0] ent_s4 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: signed unit components and t = 1 - c
			u_s1[0] <= flags.neg[2] ? -val_t'(quot_x) : val_t'(quot_x);
			u_s1[1] <= flags.neg[1] ? -val_t'(quot_y) : val_t'(quot_y);
			u_s1[2] <= flags.neg[0] ? -val_t'(quot_z) : val_t'(quot_z);
			c_s1    <= cos_v;
			s_s1    <= sin_v;
			t_s1    <= ONE_Q30 - cos_v;
			zero_s1 <= flags.zero;

			// stage 2: first products
			for (int j = 0; j < 3; j++) begin
				tu_s2[j] <= mul_q30(t_s1, u_s1[j]);
				su_s2[j] <= mul_q30(s_s1, u_s1[j]);
				u_s2[j]  <= u_s1[j];
			end
			c_s2    <= c_s1;
			zero_s2 <= zero_s1;

			// stage 3: second products
			txx_s3  <= mul_q30(tu_s2[0], u_s2[0]);
			txy_s3  <= mul_q30(tu_s2[0], u_s2[1]);
			txz_s3  <= mul_q30(tu_s2[0], u_s2[2]);
			tyy_s3  <= mul_q30(tu_s2[1], u_s2[1]);
			tyz_s3  <= mul_q30(tu_s2[1], u_s2[2]);
			tzz_s3  <= mul_q30(tu_s2[2], u_s2[2]);
			su_s3   <= su_s2;
			c_s3    <= c_s2;
			zero_s3 <= zero_s2;

			// stage 4: sums, rounding, saturation
			if (zero_s3) begin
				for (int j = 0; j < 9; j++) begin
					ent_s4[j] <= '0;
				end
			end else begin
				ent_s4[0] <= to_out((VAL_W+1)'(txx_s3) + (VAL_W+1)'(c_s3));
				ent_s4[1] <= to_out((VAL_W+1)'(txy_s3) + (VAL_W+1)'(su_s3[2]));
				ent_s4[2] <= to_out((VAL_W+1)'(txz_s3) - (VAL_W+1)'(su_s3[1]));
				ent_s4[3] <= to_out((VAL_W+1)'(txy_s3) - (VAL_W+1)'(su_s3[2]));
				ent_s4[4] <= to_out((VAL_W+1)'(tyy_s3) + (VAL_W+1)'(c_s3));
				ent_s4[5] <= to_out((VAL_W+1)'(tyz_s3) + (VAL_W+1)'(su_s3[0]));
				ent_s4[6] <= to_out((VAL_W+1)'(txz_s3) + (VAL_W+1)'(su_s3[1]));
				ent_s4[7] <= to_out((VAL_W+1)'(tyz_s3) - (VAL_W+1)'(su_s3[0]));
				ent_s4[8] <= to_out((VAL_W+1)'(tzz_s3) + (VAL_W+1)'(c_s3));
			end
			zero_s4 <= zero_s3;
		end
	end

	assign out_vld = vld_s4;
	assign ent     = ent_s4;
	assign zero    = zero_s4;

endmodule

`default_nettype wire

/* src/axis_angle_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix
// rodrigues rotation matrix from an axis and an angle, fully pipelined
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | axis_x, axis_y, axis_z, angle_deg
//  out     | out_valid / out_stall | row0_col0 .. row2_col2, axis_zero
//
// one transaction per cycle unless out_stall holds a result; 2 front stages,
// 32 square root stages, 31 divider stages and 4 product stages
// the cordic runs alongside and is lined up by a shift line
// arst_n clears the valid bits only; data registers come up undefined
// while a result waits under out_stall every stage holds and in_stall is high
// ----------------------------------------------------------------------------
`default_nettype none

module axis_angle_to_rotation_matrix import aarm_pkg::*; #(
	parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  wire  logic                    clk,
	input  wire  logic                    arst_n,
	input  wire  logic                    in_valid,
	output logic                          in_stall,
	input  wire  logic signed [AX_W-1:0]  axis_x,
	input  wire  logic signed [AX_W-1:0]  axis_y,
	input  wire  logic signed [AX_W-1:0]  axis_z,
	input  wire  logic signed [ANG_W-1:0] angle_deg,
	output logic                          out_valid,
	input  wire  logic                    out_stall,
	output logic signed [OUT_W-1:0]       row0_col0,
	output logic signed [OUT_W-1:0]       row0_col1,
	output logic signed [OUT_W-1:0]       row0_col2,
	output logic signed [OUT_W-1:0]       row1_col0,
	output logic signed [OUT_W-1:0]       row1_col1,
	output logic signed [OUT_W-1:0]       row1_col2,
	output logic signed [OUT_W-1:0]       row2_col0,
	output logic signed [OUT_W-1:0]       row2_col1,
	output logic signed [OUT_W-1:0]       row2_col2,
	output logic                          axis_zero
);

	localparam int ALIGN_DEPTH =
		FRONT_AX + SQ_STEPS + DIV_STEPS - FRONT_ANG - (CORDIC_STEPS + 1);

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// front stages
	logic signed [31:0] ax_w, ay_w, az_w, sqx_p, sqy_p, sqz_p;
	// offset turn count, always positive and up to 16426
	logic [14:0]        hp;
	logic [25:0]        qprod;
	logic [14:0]        hm;
	logic [6:0]         hm7;
	logic [5:0]         hm6;
	logic [31:0]        zprod;

	logic        vld_s1, vld_s2;
	logic [31:0] sqx_s1, sqy_s1, sqz_s1;
	mag_t        magx_s1, magy_s1, magz_s1;
	logic [2:0]  neg_s1;
	logic [14:0] hp_s1;
	logic [8:0]  qe_s1;
	logic [9:0]  lo_s1;
	logic [L2_W-1:0] l2_s2;
	axis_tag_t   tag_s2;
	logic [15:0] r_s2;
	quad_t       quad_s3;
	logic [REM_W-1:0] rem_s3;
	quad_t       quad_s4;
	val_t        z0_s4;

	assign ax_w  = 32'(axis_x);
	assign ay_w  = 32'(axis_y);
	assign az_w  = 32'(axis_z);
	assign sqx_p = ax_w * ax_w;
	assign sqy_p = ay_w * ay_w;
	assign sqz_p = az_w * az_w;

	// 46080 = 45 * 1024: the turn count above bit 10 is reduced mod 45
	assign hp    = 15'($signed({angle_deg[ANG_W-1], angle_deg[ANG_W-1:10]}) +
		15'sd8235);
	assign qprod = 26'(hp) * 26'(RECIP_45);
	assign hm    = hp_s1 - 15'(qe_s1) * 15'(TURN_DIV);
	assign hm7   = hm[6:0];
	assign hm6   = (hm7 >= 7'(TURN_DIV)) ? 6'(hm7 - 7'(TURN_DIV)) : hm7[5:0];
	assign zprod = 32'(rem_s3) * 32'(RAD_PER_UNIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1  <= sqx_p;
			sqy_s1  <= sqy_p;
			sqz_s1  <= sqz_p;
			magx_s1 <= axis_x[AX_W-1] ? mag_t'(-axis_x) : mag_t'(axis_x);
			magy_s1 <= axis_y[AX_W-1] ? mag_t'(-axis_y) : mag_t'(axis_y);
			magz_s1 <= axis_z[AX_W-1] ? mag_t'(-axis_z) : mag_t'(axis_z);
			neg_s1  <= {axis_x[AX_W-1], axis_y[AX_W-1], axis_z[AX_W-1]};
			hp_s1   <= hp;
			qe_s1   <= qprod[24:16];
			lo_s1   <= angle_deg[9:0];

			l2_s2              <= sqx_s1 + sqy_s1 + sqz_s1;
			tag_s2.flags.zero  <= (sqx_s1 + sqy_s1 + sqz_s1) == '0;
			tag_s2.flags.neg   <= neg_s1;
			tag_s2.mag_x       <= magx_s1;
			tag_s2.mag_y       <= magy_s1;
			tag_s2.mag_z       <= magz_s1;
			r_s2               <= {hm6, lo_s1};

			if (r_s2 >= 16'(3*UNITS_QUARTER)) begin
				quad_s3 <= QUAD_270;
				rem_s3  <= REM_W'(r_s2 - 16'(3*UNITS_QUARTER));
			end else if (r_s2 >= 16'(2*UNITS_QUARTER)) begin
				quad_s3 <= QUAD_180;
				rem_s3  <= REM_W'(r_s2 - 16'(2*UNITS_QUARTER));
			end else if (r_s2 >= 16'(UNITS_QUARTER)) begin
				quad_s3 <= QUAD_90;
				rem_s3  <= REM_W'(r_s2 - 16'(UNITS_QUARTER));
			end else begin
				quad_s3 <= QUAD_0;
				rem_s3  <= REM_W'(r_s2);
			end

			quad_s4 <= quad_s3;
			z0_s4   <= val_t'(zprod);
		end
	end

	// axis path
	logic             sq_vld;
	logic [LEN_W-1:0] len;
	axis_tag_t        sq_tag;
	logic             dv_vld;
	flags_t           dv_flags;
	quot_t            qx, qy, qz;

	aarm_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.l2      (l2_s2),
		.in_tag  (tag_s2),
		.out_vld (sq_vld),
		.len     (len),
		.out_tag (sq_tag)
	);

	aarm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (sq_vld),
		.len       (len),
		.in_tag    (sq_tag),
		.out_vld   (dv_vld),
		.out_flags (dv_flags),
		.quot_x    (qx),
		.quot_y    (qy),
		.quot_z    (qz)
	);

	// angle path
	val_t cs_cos, cs_sin, al_cos, al_sin;

	aarm_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.en    (en),
		.z0    (z0_s4),
		.quad  (quad_s4),
		.cos_v (cs_cos),
		.sin_v (cs_sin)
	);

	aarm_dly #(
		.DEPTH (ALIGN_DEPTH),
		.WIDTH (2*VAL_W)
	) u_dly (
		.clk  (clk),
		.en   (en),
		.din  ({cs_cos, cs_sin}),
		.dout ({al_cos, al_sin})
	);

	logic signed [OUT_W-1:0] ent [9];

	aarm_mat #(
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_mat (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (dv_vld),
		.flags   (dv_flags),
		.quot_x  (qx),
		.quot_y  (qy),
		.quot_z  (qz),
		.cos_v   (al_cos),
		.sin_v   (al_sin),
		.out_vld (out_valid),
		.ent     (ent),
		.zero    (axis_zero)
	);

	assign row0_col0 = ent[0];
	assign row0_col1 = ent[1];
	assign row0_col2 = ent[2];
	assign row1_col0 = ent[3];
	assign row1_col1 = ent[4];
	assign row1_col2 = ent[5];
	assign row2_col0 = ent[6];
	assign row2_col1 = ent[7];
	assign row2_col2 = ent[8];

	// a held pipeline keeps its result
	a_hold_keeps_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> out_valid)
		else $error("result lost while pipeline held");

	// zero axis gives an all-zero matrix
	a_zero_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && axis_zero) |-> (row0_col0 == 0 && row0_col1 == 0 &&
		row0_col2 == 0 && row1_col0 == 0 && row1_col1 == 0 && row1_col2 == 0 &&
		row2_col0 == 0 && row2_col1 == 0 && row2_col2 == 0))
		else $error("non-zero entry for zero axis");

	// a held result stays on the ports
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> ($stable(row0_col0) && $stable(row1_col1) &&
		$stable(row2_col2) && $stable(axis_zero)))
		else $error("result changed while held");

endmodule

`default_nettype wire

/* sim/tb_axis_angle_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// tb_axis_angle_to_rotation_matrix
// drives axis/angle transactions with random gaps and output stalls, predicts
// each rotation matrix in fixed point and checks every entry and the zero flag
// ----------------------------------------------------------------------------
`default_nettype none

module tb_axis_angle_to_rotation_matrix;
	import aarm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  N_RANDOM    = 1200;
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  TAIL_CYCLES = 120;
	localparam longint FULL_TURN = 46080;

	typedef struct packed {
		logic              drain;
		logic [AX_W-1:0]   ax;
		logic [AX_W-1:0]   ay;
		logic [AX_W-1:0]   az;
		logic [ANG_W-1:0]  ang;
	} axis_item_t;

	typedef struct packed {
		logic [8:0][OUT_W-1:0] ent;
		logic                  zero;
	} matrix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	logic signed [AX_W-1:0]  axis_x = '0;
	logic signed [AX_W-1:0]  axis_y = '0;
	logic signed [AX_W-1:0]  axis_z = '0;
	logic signed [ANG_W-1:0] angle_deg = '0;
	logic in_stall, out_valid, axis_zero;
	logic signed [OUT_W-1:0] row0_col0, row0_col1, row0_col2;
	logic signed [OUT_W-1:0] row1_col0, row1_col1, row1_col2;
	logic signed [OUT_W-1:0] row2_col0, row2_col1, row2_col2;

	axis_angle_to_rotation_matrix dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle_deg(angle_deg),
		.out_valid(out_valid), .out_stall(out_stall),
		.row0_col0(row0_col0), .row0_col1(row0_col1), .row0_col2(row0_col2),
		.row1_col0(row1_col0), .row1_col1(row1_col1), .row1_col2(row1_col2),
		.row2_col0(row2_col0), .row2_col1(row2_col1), .row2_col2(row2_col2),
		.axis_zero(axis_zero)
	);

	axis_item_t pending_axes[$];
	matrix_t    expected_matrices[$];
	int         mismatches = 0;
	int         n_matrices = 0;
	int         n_zero_axes = 0;
	int         n_drains = 0;
	int         cycles = 0;
	int         in_gap = 0;
	int         stall_left = 0;
	bit         burst_in = 0;
	bit         burst_out = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint floor_shift(longint v, int sh);
		return v >>> sh;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b + (longint'(1) << 29)) >>> 30;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = longint'(1) << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unit_comp(longint v, longint unsigned len);
		longint unsigned mag;
		mag = (v < 0) ? longint'(-v) : longint'(v);
		mag = (mag << 46) / len;
		return (v < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic [OUT_W-1:0] sat_entry(longint v);
		int sh;
		sh = 30 - OUT_FRAC_BITS_DEF;
		if (sh > 0)
			v = floor_shift(v + (longint'(1) << (sh - 1)), sh);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[OUT_W-1:0];
	endfunction

	function automatic matrix_t rotation_of(axis_item_t it);
		matrix_t m;
		longint x, y, z, ang, r, rem, cx, cy, cz, dx, dy, c, s, t, ux, uy, uz;
		longint txy, txz, tyz, sx, sy, sz;
		longint unsigned l2, len;
		quad_t q;
		x = longint'($signed(it.ax));
		y = longint'($signed(it.ay));
		z = longint'($signed(it.az));
		ang = longint'($signed(it.ang));
		m = '0;
		l2 = longint'(x * x + y * y + z * z);
		if (l2 == 0) begin
			m.zero = 1'b1;
			return m;
		end
		r = ang % FULL_TURN;
		if (r < 0)
			r += FULL_TURN;
		q = quad_t'(r / UNITS_QUARTER);
		rem = r % UNITS_QUARTER;
		cx = longint'(CORDIC_GAIN_INV);
		cy = 0;
		cz = rem * longint'(RAD_PER_UNIT);
		for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cz >= 0) begin
				cx -= dx;
				cy += dy;
				cz -= longint'(ATAN_Q30[i]);
			end else begin
				cx += dx;
				cy -= dy;
				cz += longint'(ATAN_Q30[i]);
			end
		end
		case (q)
			QUAD_0:   begin c = cx;  s = cy;  end
			QUAD_90:  begin c = -cy; s = cx;  end
			QUAD_180: begin c = -cx; s = -cy; end
			default:  begin c = cy;  s = -cx; end
		endcase
		t = (longint'(1) << 30) - c;
		len = int_sqrt(l2 << 32);
		ux = unit_comp(x, len);
		uy = unit_comp(y, len);
		uz = unit_comp(z, len);
		txy = qmul(qmul(t, ux), uy);
		txz = qmul(qmul(t, ux), uz);
		tyz = qmul(qmul(t, uy), uz);
		sx = qmul(s, ux);
		sy = qmul(s, uy);
		sz = qmul(s, uz);
		// entry 8 is row0_col0, entry 0 is row2_col2
		m.ent[8] = sat_entry(qmul(qmul(t, ux), ux) + c);
		m.ent[7] = sat_entry(txy + sz);
		m.ent[6] = sat_entry(txz - sy);
		m.ent[5] = sat_entry(txy - sz);
		m.ent[4] = sat_entry(qmul(qmul(t, uy), uy) + c);
		m.ent[3] = sat_entry(tyz + sx);
		m.ent[2] = sat_entry(txz + sy);
		m.ent[1] = sat_entry(tyz - sx);
		m.ent[0] = sat_entry(qmul(qmul(t, uz), uz) + c);
		return m;
	endfunction

	function automatic int random_gap(bit burst);
		int p;
		if (burst)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic add_axis(int x, int y, int z, int a, bit drain);
		axis_item_t it;
		it.drain = drain;
		it.ax = x[AX_W-1:0];
		it.ay = y[AX_W-1:0];
		it.az = z[AX_W-1:0];
		it.ang = a[ANG_W-1:0];
		pending_axes.push_back(it);
	endtask

	// input driver
	always @(posedge clk) begin
		axis_item_t it;
		logic nv;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (in_valid && !in_stall) begin
				expected_matrices.push_back(rotation_of({1'b0, axis_x, axis_y, axis_z,
					angle_deg}));
				if ($urandom_range(0, 99) == 0)
					burst_in = ~burst_in;
			end
			if (!(in_valid && in_stall)) begin
				nv = 1'b0;
				if (in_gap > 0) begin
					in_gap--;
				end else if (pending_axes.size() > 0 &&
						!(pending_axes[0].drain && expected_matrices.size() > 0)) begin
					it = pending_axes.pop_front();
					if (it.drain)
						n_drains++;
					axis_x <= it.ax;
					axis_y <= it.ay;
					axis_z <= it.az;
					angle_deg <= it.ang;
					nv = 1'b1;
					in_gap = random_gap(burst_in);
				end
				in_valid <= nv;
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		matrix_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.ent = {row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
					row1_col2, row2_col0, row2_col1, row2_col2};
				got.zero = axis_zero;
				if (expected_matrices.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected matrix transaction %h", got);
				end else begin
					want = expected_matrices.pop_front();
					n_matrices++;
					if (want.zero)
						n_zero_axes++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("matrix %0d mismatch: expected %h flag %b, got %h flag %b",
								n_matrices, want.ent, want.zero, got.ent, got.zero);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				if ($urandom_range(0, 99) == 0)
					burst_out = ~burst_out;
				stall_left = random_gap(burst_out);
				out_stall <= (stall_left > 0);
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d matrices outstanding", expected_matrices.size());
			$display("tb_axis_angle_to_rotation_matrix: FAIL");
			$finish;
		end
	end

	initial begin
		int x, y, z;
		// directed: zero axis, extreme components, quadrant edges, wrap-around
		add_axis(0, 0, 0, 1000, 0);
		add_axis(0, 0, 0, -8388608, 0);
		add_axis(256, 0, 0, 0, 0);
		add_axis(0, 256, 0, 11520, 0);
		add_axis(0, 0, 256, 23040, 0);
		add_axis(256, 256, 256, 34560, 0);
		add_axis(1, 0, 0, 46080, 0);
		add_axis(0, -1, 0, 11519, 0);
		add_axis(-32768, -32768, -32768, -1, 0);
		add_axis(32767, 32767, 32767, 8388607, 0);
		add_axis(-32768, 32767, 0, -8388608, 0);
		add_axis(32767, -32768, 1, 5760, 0);
		add_axis(0, 0, -32768, -46080, 0);
		add_axis(100, -200, 300, 46079, 1);
		add_axis(-256, 0, 0, 17280, 0);
		add_axis(1, 1, 1, -11520, 0);
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				x = $urandom_range(0, 512) - 256;
				y = $urandom_range(0, 512) - 256;
				z = $urandom_range(0, 512) - 256;
			end else begin
				x = $urandom;
				y = $urandom;
				z = $urandom;
			end
			if ($urandom_range(0, 49) == 0) begin
				x = 0; y = 0; z = 0;
			end
			add_axis(x, y, z, $urandom, (i % 300) == 150);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_axes.size() > 0 || in_valid)
			@(posedge clk);
		while (expected_matrices.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("checked %0d matrices (%0d zero axes), %0d drain pauses, %0d cycles",
			n_matrices, n_zero_axes, n_drains, cycles);
		$display("covered extreme axes, all quadrants, negative and wrapped angles");
		if (mismatches == 0 && expected_matrices.size() == 0)
			$display("tb_axis_angle_to_rotation_matrix: PASS");
		else
			$display("tb_axis_angle_to_rotation_matrix: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

/* axis_angle_to_rotation_matrix.f */
src/aarm_pkg.sv
src/aarm_cordic.sv
src/aarm_isqrt.sv
src/aarm_div.sv
src/aarm_dly.sv
src/aarm_mat.sv
src/axis_angle_to_rotation_matrix.sv
sim/tb_axis_angle_to_rotation_matrix.sv
